>>> hdl/etcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Types and constants for the edge timestamp capture FIFO.
// Used by the top level; no dependencies.
package etcf_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned CFG_W   = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd48;
  localparam logic               IDLE_RESET  = 1'b0;

  localparam logic CFG_NEAR_FULL_LEVEL = 1'b0;
  localparam logic CFG_NEAR_FULL_IDLE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    OP_EDGE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_RESET = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

endpackage
`default_nettype wire

>>> hdl/edge_timestamp_capture_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Edge timestamp capture FIFO, top level.
// Depends on etcf_pkg and etcf_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command item:
//   edge event, start, stop, reset or read, plus the edge time.
//   Output channel (out_valid_o / out_ready_i) returns one status item per
//   command: command status, run flag, occupancy, first timestamp, the
//   popped timestamp on a read, and the near-full line.
//   Timestamps live in one RAM of FIFO_DEPTH x 64 bits with a registered read.
//   Every command but a read of a nonempty FIFO writes its result straight
//   into the output register; a read that pops an entry goes through the
//   RAM read register and the ST_READ state first. Throughput: one item per
//   cycle while the receiver keeps up; a popping read holds off the next item.
//   The output register parts the two sides: a new item is taken while the
//   previous result is being taken in the same cycle. If the receiver stalls,
//   the result holds and in_ready_o drops until it is taken.
//   Reset (rst_ni low) empties the FIFO, stops capture, sets the first
//   timestamp to all ones, the near-full level to 48 and the idle near-full
//   value to 0. The RAM needs no clearing; entries are read only once held.
//   Configuration writes (cfg_we_i) take effect at once and are meant for
//   idle periods only.
module edge_timestamp_capture_fifo
  import etcf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [TIME_W-1:0]  edge_time_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    command_status_o,
  output logic                    running_o,
  output logic [LEVEL_W-1:0]      event_count_o,
  output logic [TIME_W-1:0]       first_time_o,
  output logic [TIME_W-1:0]       read_time_o,
  output logic                    read_valid_o,
  output logic                    near_full_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MW = (CW > LEVEL_W) ? CW : LEVEL_W;

  localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);

  state_e            state_q, state_d;
  logic [AW-1:0]     wr_slot_q, wr_slot_d;
  logic [AW-1:0]     rd_slot_q, rd_slot_d;
  logic [CW-1:0]     count_q, count_d;
  logic              started_q, started_d;
  logic [TIME_W-1:0] first_q, first_d;
  logic              first_vld_q, first_vld_d;
  logic              nf_q, nf_d;
  logic [LEVEL_W-1:0] level_q;
  logic              idle_val_q;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic              out_running_q, out_running_d;
  logic [LEVEL_W-1:0] out_count_q, out_count_d;
  logic [TIME_W-1:0] out_first_q, out_first_d;
  logic [TIME_W-1:0] out_rtime_q, out_rtime_d;
  logic              out_rvalid_q, out_rvalid_d;
  logic              out_nf_q, out_nf_d;

  logic              accept;
  logic              ram_we, ram_re;
  logic [TIME_W-1:0] ram_rdata;
  logic              pop;

  etcf_ram #(
    .WIDTH (TIME_W),
    .DEPTH (FIFO_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot_q),
    .wdata_i (edge_time_i),
    .re_i    (ram_re),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    wr_slot_d     = wr_slot_q;
    rd_slot_d     = rd_slot_q;
    count_d       = count_q;
    started_d     = started_q;
    first_d       = first_q;
    first_vld_d   = first_vld_q;
    nf_d          = nf_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    pop           = 1'b0;
    out_status_d  = out_status_q;
    out_running_d = out_running_q;
    out_count_d   = out_count_q;
    out_first_d   = out_first_q;
    out_rtime_d   = out_rtime_q;
    out_rvalid_d  = out_rvalid_q;
    out_nf_d      = out_nf_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_status_d = STATUS_OK;
          case (op_e'(operation_i))
            OP_EDGE: begin
              if (started_q) begin
                if (count_q != FULL_CNT) begin
                  ram_we    = 1'b1;
                  wr_slot_d = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
                  count_d   = count_q + 1'b1;
                  nf_d      = MW'(count_d) >= MW'(level_q);
                  if (!first_vld_q) begin
                    first_d     = edge_time_i;
                    first_vld_d = 1'b1;
                  end
                end else begin
                  // full: drop the edge and stop capture
                  started_d = 1'b0;
                end
              end
            end
            OP_START: started_d = 1'b1;
            OP_STOP:  started_d = 1'b0;
            OP_RESET: begin
              if (started_q) begin
                out_status_d = STATUS_FAIL;
              end else begin
                wr_slot_d   = '0;
                rd_slot_d   = '0;
                count_d     = '0;
                first_d     = '1;
                first_vld_d = 1'b0;
                nf_d        = idle_val_q;
              end
            end
            OP_READ: begin
              if (count_q == '0) begin
                out_status_d = STATUS_FAIL;
              end else begin
                pop       = 1'b1;
                ram_re    = 1'b1;
                rd_slot_d = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
                count_d   = count_q - 1'b1;
              end
              nf_d = MW'(count_d) >= MW'(level_q);
            end
            default: out_status_d = STATUS_FAIL;
          endcase
          out_running_d = started_d;
          out_count_d   = LEVEL_W'(count_d);
          out_first_d   = first_d;
          out_nf_d      = nf_d;
          out_rtime_d   = '0;
          out_rvalid_d  = pop;
          // hold the result back until the RAM data arrives
          out_valid_d   = !pop;
          if (pop) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        out_rtime_d = ram_rdata;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      count_q     <= '0;
      started_q   <= 1'b0;
      first_q     <= '1;
      first_vld_q <= 1'b0;
      nf_q        <= IDLE_RESET;
      level_q     <= LEVEL_RESET;
      idle_val_q  <= IDLE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      count_q     <= count_d;
      started_q   <= started_d;
      first_q     <= first_d;
      first_vld_q <= first_vld_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NEAR_FULL_LEVEL) begin
          level_q <= cfg_data_i[LEVEL_W-1:0];
        end else begin
          idle_val_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_running_q <= out_running_d;
    out_count_q   <= out_count_d;
    out_first_q   <= out_first_d;
    out_rtime_q   <= out_rtime_d;
    out_rvalid_q  <= out_rvalid_d;
    out_nf_q      <= out_nf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign command_status_o = out_status_q;
  assign running_o        = out_running_q;
  assign event_count_o    = out_count_q;
  assign first_time_o     = out_first_q;
  assign read_time_o      = out_rtime_q;
  assign read_valid_o     = out_rvalid_q;
  assign near_full_o      = out_nf_q;

endmodule
`default_nettype wire

>>> hdl/etcf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etcf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_edge_timestamp_capture_fifo.sv
`timescale 1ns / 1ps
// Self-checking testbench for edge_timestamp_capture_fifo: sends command items,
// predicts every status item from a shadow FIFO and checks it field by field.
// Depends on etcf_pkg and the block's RTL.
module tb_edge_timestamp_capture_fifo;
  import etcf_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned SLOT_W      = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_MID = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic               status;
    logic               running;
    logic [LEVEL_W-1:0] count;
    logic [TIME_W-1:0]  first;
    logic [TIME_W-1:0]  rtime;
    logic               rvalid;
    logic               nf;
  } status_item_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = CFG_NEAR_FULL_LEVEL;
  logic [CFG_W-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [2:0]         operation_i = OP_EDGE;
  logic [TIME_W-1:0]  edge_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               command_status_o;
  logic               running_o;
  logic [LEVEL_W-1:0] event_count_o;
  logic [TIME_W-1:0]  first_time_o;
  logic [TIME_W-1:0]  read_time_o;
  logic               read_valid_o;
  logic               near_full_o;

  edge_timestamp_capture_fifo #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .edge_time_i      (edge_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_status_o (command_status_o),
    .running_o        (running_o),
    .event_count_o    (event_count_o),
    .first_time_o     (first_time_o),
    .read_time_o      (read_time_o),
    .read_valid_o     (read_valid_o),
    .near_full_o      (near_full_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the capture FIFO and its registers
  logic [TIME_W-1:0]  stamp_mem [DEPTH];
  logic [SLOT_W-1:0]  wr_slot;
  logic [SLOT_W-1:0]  rd_slot;
  logic [LEVEL_W-1:0] held;
  logic               started;
  logic               first_seen;
  logic [TIME_W-1:0]  first_stamp;
  logic               nf_line;
  logic [CFG_W-1:0]   nf_level;
  logic               nf_idle;

  status_item_t status_due [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  gap_pct     = 31;
  int unsigned  stall_pct   = 31;
  int unsigned  hold_left   = 0;

  function automatic status_item_t predict_status(logic [2:0] op, logic [TIME_W-1:0] t);
    status_item_t r;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      OP_EDGE: begin
        if (started) begin
          if (held < LEVEL_W'(DEPTH)) begin
            stamp_mem[wr_slot] = t;
            wr_slot = wr_slot + 1'b1;
            held++;
            nf_line = (held >= nf_level);
            if (!first_seen) begin
              first_stamp = t;
              first_seen  = 1'b1;
            end
          end else begin
            // full: drop the edge and stop capture
            started = 1'b0;
          end
        end
      end
      OP_START: started = 1'b1;
      OP_STOP:  started = 1'b0;
      OP_RESET: begin
        if (started) begin
          r.status = STATUS_FAIL;
        end else begin
          wr_slot     = '0;
          rd_slot     = '0;
          held        = '0;
          first_stamp = ALL_ONES;
          first_seen  = 1'b0;
          nf_line     = nf_idle;
        end
      end
      OP_READ: begin
        if (held == '0) begin
          r.status = STATUS_FAIL;
        end else begin
          r.rtime  = stamp_mem[rd_slot];
          r.rvalid = 1'b1;
          rd_slot  = rd_slot + 1'b1;
          held--;
        end
        nf_line = (held >= nf_level);
      end
      default: r.status = STATUS_FAIL;
    endcase
    r.running = started;
    r.count   = held;
    r.first   = first_stamp;
    r.nf      = nf_line;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic compare_field(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check the result taken at this edge, then predict the item taken at it
  always @(posedge clk_i) begin : score
    status_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = status_due.pop_front();
        compare_field("command_status", TIME_W'(command_status_o), TIME_W'(want.status));
        compare_field("running", TIME_W'(running_o), TIME_W'(want.running));
        compare_field("event_count", TIME_W'(event_count_o), TIME_W'(want.count));
        compare_field("first_time", first_time_o, want.first);
        compare_field("read_time", read_time_o, want.rtime);
        compare_field("read_valid", TIME_W'(read_valid_o), TIME_W'(want.rvalid));
        compare_field("near_full", TIME_W'(near_full_o), TIME_W'(want.nf));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      status_due.push_back(predict_status(operation_i, edge_time_i));
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Leaves valid high on return; a pause lowers it, as may a gap in the next call
  task automatic send_item(logic [2:0] op, logic [TIME_W-1:0] t);
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    edge_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NEAR_FULL_LEVEL) nf_level = val;
    else nf_idle = val[0];
  endtask

  function automatic logic [TIME_W-1:0] pick_stamp();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly edges and reads; control ops and spares now and then
  function automatic logic [2:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return OP_EDGE;
    if (roll < 80) return OP_READ;
    if (roll < 88) return OP_START;
    if (roll < 93) return OP_STOP;
    if (roll < 97) return OP_RESET;
    return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) send_item(pick_op(), pick_stamp());
  endtask

  task automatic restart_capture();
    send_item(OP_STOP, pick_stamp());
    send_item(OP_RESET, pick_stamp());
    send_item(OP_START, pick_stamp());
  endtask

  task automatic test_directed();
    send_item(OP_READ, '0);                 // read from empty
    send_item(OP_EDGE, 64'h0123_4567_89ab_cdef);  // edge while stopped
    send_item(OP_RESET, ALL_ONES);          // reset while stopped
    send_item(OP_START, '0);
    send_item(OP_RESET, '0);                // reset while started fails
    send_item(OP_EDGE, ALL_ONES);           // first store of all ones
    send_item(OP_EDGE, '0);
    send_item(OP_EDGE, {32{2'b01}});
    send_item(OP_EDGE, {32{2'b10}});
    repeat (4) send_item(OP_READ, '0);
    send_item(OP_READ, ALL_ONES);           // empty again
    send_item(OP_SPARE_LO, '0);
    send_item(OP_SPARE_MID, ALL_ONES);
    send_item(OP_SPARE_HI, {32{2'b10}});
    send_item(OP_STOP, '0);
    send_item(OP_RESET, '0);
    send_item(OP_START, '0);
    send_item(OP_EDGE, {$urandom, $urandom});
    send_item(OP_EDGE, {$urandom, $urandom});
    send_item(OP_READ, '0);
    send_item(OP_STOP, '0);
  endtask

  // Fill to the top, overflow twice, then drain past empty
  task automatic test_overflow();
    pause_until_drained();
    write_reg(CFG_NEAR_FULL_LEVEL, 7'(DEPTH));
    write_reg(CFG_NEAR_FULL_IDLE, CFG_W'(1'b1));
    restart_capture();
    repeat (DEPTH) send_item(OP_EDGE, pick_stamp());
    send_item(OP_EDGE, pick_stamp());
    send_item(OP_EDGE, pick_stamp());
    send_item(OP_START, '0);
    send_item(OP_EDGE, pick_stamp());
    repeat (DEPTH + 1) send_item(OP_READ, pick_stamp());
  endtask

  task automatic test_level_sweep();
    logic [CFG_W-1:0] levels [5];
    levels = '{7'd0, 7'd1, 7'd127, 7'(DEPTH), 7'($urandom_range(DEPTH, 2))};
    foreach (levels[i]) begin
      pause_until_drained();
      write_reg(CFG_NEAR_FULL_LEVEL, levels[i]);
      write_reg(CFG_NEAR_FULL_IDLE, CFG_W'(1'(i)));
      restart_capture();
      repeat (20) send_item(OP_EDGE, pick_stamp());
      send_random(27);
    end
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    pause_until_drained();
    gap_pct   = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_left = 120;
    send_item(OP_START, '0);
    repeat (15) send_item(OP_EDGE, pick_stamp());
    send_random(15);
    pause_until_drained();
    gap_pct   = 31;
    stall_pct = 31;
  endtask

  task automatic test_random_mix();
    send_random(100);
    pause_until_drained();
    gap_pct   = 0;
    stall_pct = 0;
    send_random(60);
    gap_pct   = 31;
    stall_pct = 31;
    send_random(80);
  endtask

  initial begin
    wr_slot     = '0;
    rd_slot     = '0;
    held        = '0;
    started     = 1'b0;
    first_seen  = 1'b0;
    first_stamp = ALL_ONES;
    nf_level    = LEVEL_RESET;
    nf_idle     = IDLE_RESET;
    nf_line     = IDLE_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_overflow();
    test_level_sweep();
    test_backpressure();
    test_random_mix();

    pause_until_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
